// ----- design/project_point_along_rejected_axis_unit_defines.svh -----
`ifndef PROJECT_POINT_ALONG_REJECTED_AXIS_UNIT_DEFINES_SVH
`define PROJECT_POINT_ALONG_REJECTED_AXIS_UNIT_DEFINES_SVH

// Shared assertion macros. They expect clk_i and rst_ni in the enclosing module.

// The consequent must hold in the same cycle as the antecedent.
`define PRA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pra_pkg.sv -----
`default_nettype none

package pra_pkg;

  // Field and datapath widths.
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned DMAG_W      = WORD_W + 1;
  localparam int unsigned NORM_W      = 30;
  localparam int unsigned SQ_W        = 2 * NORM_W + 2;
  localparam int unsigned ROOT_W      = NORM_W + 1;
  localparam int unsigned NUM_W       = DMAG_W + NORM_W;
  localparam int unsigned QUOT_W      = DMAG_W + 1;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_ADDR_W  = 3;

  // Register index of the threshold register.
  localparam logic REG_MIN_DIR_Y = 1'b0;

  typedef enum logic [1:0] {
    ST_PROJECTED = 2'd0,
    ST_ZERO_LEN  = 2'd1,
    ST_BELOW     = 2'd2
  } pra_status_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] axis_x;
    logic signed [WORD_W-1:0] axis_y;
    logic signed [WORD_W-1:0] axis_z;
    logic signed [WORD_W-1:0] dir_x;
    logic signed [WORD_W-1:0] dir_y;
    logic signed [WORD_W-1:0] dir_z;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] target_height;
    logic signed [WORD_W-1:0] ref_height;
    logic                     force_project;
  } pra_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] out_x;
    logic signed [WORD_W-1:0] out_y;
    logic signed [WORD_W-1:0] out_z;
    logic [1:0]               status;
  } pra_out_t;

  // Classified item held in the queue; index 0 is x.
  typedef struct packed {
    logic [2:0][WORD_W-1:0] axis;
    logic [2:0][WORD_W-1:0] dir;
    logic [2:0][WORD_W-1:0] pos;
    logic [WORD_W:0]        delta;
    logic                   proj;
  } pra_item_t;

  // Values that ride along the back-end pipeline.
  typedef struct packed {
    logic [2:0][WORD_W-1:0] pos;
    logic [DMAG_W-1:0]      dmag;
    logic                   dneg;
    pra_status_e            status;
    logic [2:0]             neg;
    logic [2:0][NORM_W-1:0] nmag;
  } pra_side_t;

endpackage

`default_nettype wire

// ----- design/pra_chan_if.sv -----
`default_nettype none

// Valid/ready channel carrying one payload per transfer.
interface pra_chan_if #(
  parameter type payload_t = pra_pkg::pra_in_t
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/project_point_along_rejected_axis_unit.sv -----
// Moves a point along the part of an axis orthogonal to a direction.
// Input channel in_i carries one item per transfer: axis, direction, base
// position, target and reference heights, and a force flag. Output channel
// out_o carries one result per item, in order: the saturated point and a
// status (projected, zero-length fallback, or below threshold).
// The threshold min_dir_y sits at APB address 0; the user is to write it
// only while idle, which the block itself does not enforce.
// Throughput is one item per clock while the output is not held; the back
// end is a fully pipelined chain of multiplier stages, a 31-stage square
// root and a 34-stage divider.
// An input transfer goes into a four-entry queue; the input stays ready while
// the queue has room, even while the back end is stalled.
// When a held-off ready stalls a waiting result, the back-end pipeline freezes
// in place and the queue absorbs up to four more items before ready drops.
// Reset clears the queue, all pipeline valid bits and the threshold register.
`default_nettype none

module project_point_along_rejected_axis_unit #(
  parameter int unsigned QUEUE_DEPTH = pra_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pra_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pra_pkg::WORD_W-1:0]     pwdata,
  output logic [pra_pkg::WORD_W-1:0]     prdata,
  output logic                           pready,
  pra_chan_if.sink                       in_i,
  pra_chan_if.source                     out_o
);

  logic               push;
  logic               full;
  logic               pop;
  logic               q_valid;
  pra_pkg::pra_item_t push_item;
  pra_pkg::pra_item_t q_item;

  pra_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .item_o  (push_item)
  );

  pra_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  pra_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ----- design/pra_front.sv -----
`default_nettype none

module pra_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pra_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pra_pkg::WORD_W-1:0]     pwdata,
  output logic [pra_pkg::WORD_W-1:0]     prdata,
  output logic                           pready,
  pra_chan_if.sink                       in_i,
  input  logic                           full_i,
  output logic                           push_o,
  output pra_pkg::pra_item_t             item_o
);

  localparam int unsigned W = pra_pkg::WORD_W;
  localparam int unsigned AW = pra_pkg::CFG_ADDR_W;

  logic [W-1:0] min_dir_y_q;
  logic         reg_sel;

  // The register index is the address above the byte offset.
  assign reg_sel = (paddr[AW-1] == pra_pkg::REG_MIN_DIR_Y);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? min_dir_y_q : '0;

  // Threshold register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dir_y_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      min_dir_y_q <= pwdata;
    end
  end

  // Accept whenever the queue has room.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Classify the item and form the exact height difference.
  always_comb begin
    item_o.axis[0] = in_i.data.axis_x;
    item_o.axis[1] = in_i.data.axis_y;
    item_o.axis[2] = in_i.data.axis_z;
    item_o.dir[0]  = in_i.data.dir_x;
    item_o.dir[1]  = in_i.data.dir_y;
    item_o.dir[2]  = in_i.data.dir_z;
    item_o.pos[0]  = in_i.data.pos_x;
    item_o.pos[1]  = in_i.data.pos_y;
    item_o.pos[2]  = in_i.data.pos_z;
    item_o.delta   = {in_i.data.target_height[W-1], in_i.data.target_height}
                   - {in_i.data.ref_height[W-1], in_i.data.ref_height};
    item_o.proj    = in_i.data.force_project
                   || ($signed(min_dir_y_q) <= in_i.data.dir_y);
  end

endmodule

`default_nettype wire

// ----- design/pra_fifo.sv -----
`default_nettype none
`include "project_point_along_rejected_axis_unit_defines.svh"

module pra_fifo #(
  parameter int unsigned DEPTH = pra_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pra_pkg::pra_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output pra_pkg::pra_item_t item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pra_pkg::pra_item_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `PRA_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue fill level overflow")
  `PRA_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "transfer into a full queue")
  `PRA_ASSERT_IMPL(a_no_pop_empty, pop_i, valid_o, "back end popped an empty queue")

endmodule

`default_nettype wire

// ----- design/pra_isqrt.sv -----
`default_nettype none

// Pipelined floor square root, one result bit per stage.
module pra_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  pra_pkg::pra_side_t             side_i,
  input  logic [pra_pkg::SQ_W-1:0]       x_i,
  output logic                           valid_o,
  output pra_pkg::pra_side_t             side_o,
  output logic [pra_pkg::ROOT_W-1:0]     root_o
);

  localparam int unsigned RW = pra_pkg::ROOT_W;
  localparam int unsigned XW = pra_pkg::SQ_W;
  localparam int unsigned TW = XW + 2;

  logic               v_q    [RW];
  pra_pkg::pra_side_t side_q [RW];
  logic [XW-1:0]      rem_q  [RW];
  logic [RW-1:0]      root_q [RW];

  logic               v_d    [RW];
  pra_pkg::pra_side_t side_d [RW];
  logic [XW-1:0]      rem_d  [RW];
  logic [RW-1:0]      root_d [RW];

  // Each stage tries the next root bit against the running remainder.
  always_comb begin
    logic [XW-1:0] rin;
    logic [RW-1:0] qin;
    logic [TW-1:0] trial;
    for (int j = 0; j < RW; j++) begin
      if (j == 0) begin
        v_d[j]    = valid_i;
        side_d[j] = side_i;
        rin       = x_i;
        qin       = '0;
      end else begin
        v_d[j]    = v_q[j-1];
        side_d[j] = side_q[j-1];
        rin       = rem_q[j-1];
        qin       = root_q[j-1];
      end
      trial = (TW'(qin) << (RW - j)) | (TW'(1) << (2 * (RW - 1 - j)));
      if (TW'(rin) >= trial) begin
        rem_d[j]  = XW'(TW'(rin) - trial);
        root_d[j] = qin | (RW'(1) << (RW - 1 - j));
      end else begin
        rem_d[j]  = rin;
        root_d[j] = qin;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < RW; j++) begin
        v_q[j] <= 1'b0;
      end
    end else if (en_i) begin
      for (int j = 0; j < RW; j++) begin
        v_q[j] <= v_d[j];
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < RW; j++) begin
        side_q[j] <= side_d[j];
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign side_o  = side_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule

`default_nettype wire

// ----- design/pra_div.sv -----
`default_nettype none

// Pipelined restoring divider, three numerators over one divisor,
// one quotient bit per stage.
module pra_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  pra_pkg::pra_side_t                  side_i,
  input  logic [2:0][pra_pkg::NUM_W-1:0]      num_i,
  input  logic [pra_pkg::ROOT_W-1:0]          den_i,
  output logic                                valid_o,
  output pra_pkg::pra_side_t                  side_o,
  output logic [2:0][pra_pkg::QUOT_W-1:0]     quot_o
);

  localparam int unsigned QW = pra_pkg::QUOT_W;
  localparam int unsigned NW = pra_pkg::NUM_W;
  localparam int unsigned RW = pra_pkg::ROOT_W;
  localparam int unsigned DW = RW + QW;

  logic                  v_q    [QW];
  pra_pkg::pra_side_t    side_q [QW];
  logic [RW-1:0]         den_q  [QW];
  logic [2:0][NW-1:0]    rem_q  [QW];
  logic [2:0][QW-1:0]    quo_q  [QW];

  logic                  v_d    [QW];
  pra_pkg::pra_side_t    side_d [QW];
  logic [RW-1:0]         den_d  [QW];
  logic [2:0][NW-1:0]    rem_d  [QW];
  logic [2:0][QW-1:0]    quo_d  [QW];

  // Each stage subtracts the shifted divisor where it fits.
  always_comb begin
    logic [2:0][NW-1:0] rin;
    logic [2:0][QW-1:0] qin;
    logic [DW-1:0]      dsh;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        v_d[j]    = valid_i;
        side_d[j] = side_i;
        den_d[j]  = den_i;
        rin       = num_i;
        qin       = '0;
      end else begin
        v_d[j]    = v_q[j-1];
        side_d[j] = side_q[j-1];
        den_d[j]  = den_q[j-1];
        rin       = rem_q[j-1];
        qin       = quo_q[j-1];
      end
      dsh = DW'(den_d[j]) << (QW - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if (DW'(rin[k]) >= dsh) begin
          rem_d[j][k] = NW'(DW'(rin[k]) - dsh);
          quo_d[j][k] = qin[k] | (QW'(1) << (QW - 1 - j));
        end else begin
          rem_d[j][k] = rin[k];
          quo_d[j][k] = qin[k];
        end
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < QW; j++) begin
        v_q[j] <= 1'b0;
      end
    end else if (en_i) begin
      for (int j = 0; j < QW; j++) begin
        v_q[j] <= v_d[j];
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < QW; j++) begin
        side_q[j] <= side_d[j];
        den_q[j]  <= den_d[j];
        rem_q[j]  <= rem_d[j];
        quo_q[j]  <= quo_d[j];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign side_o  = side_q[QW-1];
  assign quot_o  = quo_q[QW-1];

endmodule

`default_nettype wire

// ----- design/pra_back.sv -----
`default_nettype none

module pra_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  pra_pkg::pra_item_t item_i,
  output logic               pop_o,
  pra_chan_if.source         out_o
);

  localparam int unsigned W    = pra_pkg::WORD_W;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned CW   = 2 * W + 1;
  localparam int unsigned LW   = $clog2(PW + 1);
  localparam int unsigned NW   = pra_pkg::NORM_W;
  localparam int unsigned SW   = pra_pkg::SQ_W;
  localparam int unsigned RW   = pra_pkg::ROOT_W;
  localparam int unsigned QW   = pra_pkg::QUOT_W;
  localparam int unsigned NUMW = pra_pkg::NUM_W;
  localparam int unsigned EW   = W + 4;

  // Bit length of an unsigned word.
  function automatic logic [LW-1:0] bit_len(input logic [PW-1:0] v);
    logic [LW-1:0] n;
    n = '0;
    for (int i = 0; i < PW; i++) begin
      if (v[i]) begin
        n = LW'(i + 1);
      end
    end
    return n;
  endfunction

  // Signed 32 by 32 product.
  function automatic logic [PW-1:0] smul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic signed [PW-1:0] r;
    r = $signed(a) * $signed(b);
    return r;
  endfunction

  // Magnitude of a two's complement cross component.
  function automatic logic [PW-1:0] cmag(input logic [CW-1:0] v);
    logic [CW-1:0] m;
    m = v[CW-1] ? (~v + 1'b1) : v;
    return m[PW-1:0];
  endfunction

  logic en;
  logic out_valid_q;
  pra_pkg::pra_out_t out_data_q;

  // The whole back end moves together unless the output is held.
  assign en    = !out_valid_q || out_o.ready;
  assign pop_o = en && item_valid_i;

  logic [12:1] v_q;

  pra_pkg::pra_side_t     s1_side_q, s2_side_q, s3_side_q, s4_side_q, s5_side_q;
  pra_pkg::pra_side_t     s6_side_q, s7_side_q, s8_side_q, s9_side_q, s10_side_q;
  pra_pkg::pra_side_t     s11_side_q, s12_side_q;
  logic [2:0][W-1:0]      s1_dir_q, s2_dir_q, s3_dir_q, s4_dir_q;
  logic [5:0][PW-1:0]     s1_pr_q, s5_pr_q;
  logic [2:0][CW-1:0]     s2_c_q, s6_p_q;
  logic [2:0][PW-1:0]     s3_cm_q, s7_pm_q;
  logic [2:0]             s3_cn_q, s7_pn_q;
  logic [LW-1:0]          s3_sh_q, s7_len_q;
  logic [2:0][W-1:0]      s4_cs_q;
  logic [2:0][SW-3:0]     s9_sq_q;
  logic [SW-1:0]          s10_len2_q;
  logic [RW-1:0]          s11_root_q, s12_root_q;
  logic [2:0][NUMW-1:0]   s11_prod_q, s12_num_q;

  pra_pkg::pra_side_t     s1_side_d, s6_side_d, s8_side_d;
  logic [5:0][PW-1:0]     s1_pr_d, s5_pr_d;
  logic [2:0][CW-1:0]     s2_c_d, s6_p_d;
  logic [2:0][PW-1:0]     s3_cm_d, s7_pm_d;
  logic [2:0]             s3_cn_d, s7_pn_d;
  logic [LW-1:0]          s3_sh_d, s7_len_d;
  logic [2:0][W-1:0]      s4_cs_d;
  logic [2:0][SW-3:0]     s9_sq_d;
  logic [SW-1:0]          s10_len2_d;
  logic [2:0][NUMW-1:0]   s11_prod_d, s12_num_d;

  logic                   sq_valid;
  pra_pkg::pra_side_t     sq_side;
  logic [RW-1:0]          sq_root;
  logic                   dv_valid;
  pra_pkg::pra_side_t     dv_side;
  logic [2:0][QW-1:0]     dv_quot;
  pra_pkg::pra_out_t      out_data_d;

  // Stage 1: side values and the six products of the first cross product.
  always_comb begin
    s1_side_d        = '0;
    s1_side_d.pos    = item_i.pos;
    s1_side_d.dneg   = item_i.delta[W];
    s1_side_d.dmag   = item_i.delta[W] ? (~item_i.delta + 1'b1) : item_i.delta;
    s1_side_d.status = item_i.proj ? pra_pkg::ST_PROJECTED : pra_pkg::ST_BELOW;
    s1_pr_d[0] = smul(item_i.axis[2], item_i.dir[1]);
    s1_pr_d[1] = smul(item_i.axis[1], item_i.dir[2]);
    s1_pr_d[2] = smul(item_i.axis[0], item_i.dir[2]);
    s1_pr_d[3] = smul(item_i.axis[2], item_i.dir[0]);
    s1_pr_d[4] = smul(item_i.axis[1], item_i.dir[0]);
    s1_pr_d[5] = smul(item_i.axis[0], item_i.dir[1]);
  end

  // Stage 2: cross product components, exact.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_c_d[k] = {s1_pr_q[2*k][PW-1], s1_pr_q[2*k]}
                - {s1_pr_q[2*k+1][PW-1], s1_pr_q[2*k+1]};
    end
  end

  // Stage 3: magnitudes and the common right shift into 31 bits.
  always_comb begin
    logic [PW-1:0] any;
    logic [LW-1:0] blen;
    for (int k = 0; k < 3; k++) begin
      s3_cm_d[k] = cmag(s2_c_q[k]);
      s3_cn_d[k] = s2_c_q[k][CW-1];
    end
    any  = s3_cm_d[0] | s3_cm_d[1] | s3_cm_d[2];
    blen = bit_len(any);
    s3_sh_d = (blen > LW'(W - 1)) ? (blen - LW'(W - 1)) : '0;
  end

  // Stage 4: scaled first cross product.
  always_comb begin
    logic [PW-1:0] shifted;
    logic [W-1:0]  m;
    for (int k = 0; k < 3; k++) begin
      shifted    = s3_cm_q[k] >> s3_sh_q;
      m          = {1'b0, shifted[W-2:0]};
      s4_cs_d[k] = s3_cn_q[k] ? (~m + 1'b1) : m;
    end
  end

  // Stage 5: products of the second cross product.
  always_comb begin
    s5_pr_d[0] = smul(s4_cs_q[1], s4_dir_q[2]);
    s5_pr_d[1] = smul(s4_cs_q[2], s4_dir_q[1]);
    s5_pr_d[2] = smul(s4_cs_q[2], s4_dir_q[0]);
    s5_pr_d[3] = smul(s4_cs_q[0], s4_dir_q[2]);
    s5_pr_d[4] = smul(s4_cs_q[0], s4_dir_q[1]);
    s5_pr_d[5] = smul(s4_cs_q[1], s4_dir_q[0]);
  end

  // Stage 6: rejected vector and the zero-length check.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s6_p_d[k] = {s5_pr_q[2*k][PW-1], s5_pr_q[2*k]}
                - {s5_pr_q[2*k+1][PW-1], s5_pr_q[2*k+1]};
    end
    s6_side_d = s5_side_q;
    if ((s5_side_q.status == pra_pkg::ST_PROJECTED)
        && (s6_p_d[0] == '0) && (s6_p_d[1] == '0) && (s6_p_d[2] == '0)) begin
      s6_side_d.status = pra_pkg::ST_ZERO_LEN;
    end
  end

  // Stage 7: magnitudes and bit length of the rejected vector.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s7_pm_d[k] = cmag(s6_p_q[k]);
      s7_pn_d[k] = s6_p_q[k][CW-1];
    end
    s7_len_d = bit_len(s7_pm_d[0] | s7_pm_d[1] | s7_pm_d[2]);
  end

  // Stage 8: normalize so that the largest magnitude has 30 bits.
  always_comb begin
    logic [PW-1:0] t;
    s8_side_d = s7_side_q;
    for (int k = 0; k < 3; k++) begin
      if (s7_len_q > LW'(NW)) begin
        t = s7_pm_q[k] >> (s7_len_q - LW'(NW));
      end else begin
        t = s7_pm_q[k] << (LW'(NW) - s7_len_q);
      end
      s8_side_d.nmag[k] = t[NW-1:0];
      s8_side_d.neg[k]  = s7_side_q.dneg ^ s7_pn_q[k];
    end
  end

  // Stage 9: squares.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s9_sq_d[k] = s8_side_q.nmag[k] * s8_side_q.nmag[k];
    end
  end

  // Stage 10: squared length.
  assign s10_len2_d = SW'(s9_sq_q[0]) + SW'(s9_sq_q[1]) + SW'(s9_sq_q[2]);

  pra_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[10]),
    .side_i  (s10_side_q),
    .x_i     (s10_len2_q),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  // Stage 11: offset length times each normalized component.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s11_prod_d[k] = sq_side.dmag * sq_side.nmag[k];
    end
  end

  // Stage 12: add half the length for round-to-nearest.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s12_num_d[k] = s11_prod_q[k] + NUMW'(s11_root_q >> 1);
    end
  end

  pra_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[12]),
    .side_i  (s12_side_q),
    .num_i   (s12_num_q),
    .den_i   (s12_root_q),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quot_o  (dv_quot)
  );

  // Final stage: signed offset, saturating add, and status select.
  always_comb begin
    logic [EW-1:0] off;
    logic [EW-1:0] sum;
    logic [W-1:0]  res [3];
    for (int k = 0; k < 3; k++) begin
      off = dv_side.neg[k] ? (~EW'(dv_quot[k]) + 1'b1) : EW'(dv_quot[k]);
      sum = {{(EW - W){dv_side.pos[k][W-1]}}, dv_side.pos[k]} + off;
      if (dv_side.status != pra_pkg::ST_PROJECTED) begin
        res[k] = dv_side.pos[k];
      end else if ((sum[EW-1:W-1] == '0) || (sum[EW-1:W-1] == '1)) begin
        res[k] = sum[W-1:0];
      end else if (sum[EW-1]) begin
        res[k] = {1'b1, {(W - 1){1'b0}}};
      end else begin
        res[k] = {1'b0, {(W - 1){1'b1}}};
      end
    end
    out_data_d.out_x  = res[0];
    out_data_d.out_y  = res[1];
    out_data_d.out_z  = res[2];
    out_data_d.status = dv_side.status;
  end

  // Valid bits of the local stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q[1]      <= item_valid_i;
      v_q[10:2]   <= v_q[9:1];
      v_q[11]     <= sq_valid;
      v_q[12]     <= v_q[11];
      out_valid_q <= dv_valid;
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q  <= s1_side_d;
      s1_dir_q   <= item_i.dir;
      s1_pr_q    <= s1_pr_d;
      s2_side_q  <= s1_side_q;
      s2_dir_q   <= s1_dir_q;
      s2_c_q     <= s2_c_d;
      s3_side_q  <= s2_side_q;
      s3_dir_q   <= s2_dir_q;
      s3_cm_q    <= s3_cm_d;
      s3_cn_q    <= s3_cn_d;
      s3_sh_q    <= s3_sh_d;
      s4_side_q  <= s3_side_q;
      s4_dir_q   <= s3_dir_q;
      s4_cs_q    <= s4_cs_d;
      s5_side_q  <= s4_side_q;
      s5_pr_q    <= s5_pr_d;
      s6_side_q  <= s6_side_d;
      s6_p_q     <= s6_p_d;
      s7_side_q  <= s6_side_q;
      s7_pm_q    <= s7_pm_d;
      s7_pn_q    <= s7_pn_d;
      s7_len_q   <= s7_len_d;
      s8_side_q  <= s8_side_d;
      s9_side_q  <= s8_side_q;
      s9_sq_q    <= s9_sq_d;
      s10_side_q <= s9_side_q;
      s10_len2_q <= s10_len2_d;
      s11_side_q <= sq_side;
      s11_root_q <= sq_root;
      s11_prod_q <= s11_prod_d;
      s12_side_q <= s11_side_q;
      s12_root_q <= s11_root_q;
      s12_num_q  <= s12_num_d;
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire

// ----- tb/project_point_along_rejected_axis_unit_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module project_point_along_rejected_axis_unit_tb;

  localparam int unsigned LATENCY     = 78;
  localparam int unsigned NUM_RANDOM  = 1530;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned ADDR_MIN_DIR_Y = 0;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pra_pkg::CFG_ADDR_W-1:0] paddr;
  logic [pra_pkg::WORD_W-1:0] pwdata;
  logic [pra_pkg::WORD_W-1:0] prdata;
  logic pready;

  pra_chan_if #(.payload_t(pra_pkg::pra_in_t)) in_ch ();
  pra_chan_if #(.payload_t(pra_pkg::pra_out_t)) out_ch ();

  project_point_along_rejected_axis_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source)
  );

  // Items waiting to be driven and results waiting to be seen.
  pra_pkg::pra_in_t  pending_points[$];
  pra_pkg::pra_out_t expected_points[$];

  logic signed [31:0] threshold;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned sent_count;
  int unsigned quiet_cycles;
  int unsigned status_seen[3];
  bit          stimulus_done;

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Common power-of-two scaling of a vector; optionally grows it into [2^lo, 2^hi).
  function automatic void scale_vector(inout logic signed [63:0] v[3], input int hi,
                                       input int lo, input bit grow);
    logic [63:0] m[3];
    bit          neg[3];
    logic [63:0] mx;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = magnitude(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'd1 << hi)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    if (grow && mx != 0) begin
      while (mx < (64'd1 << lo)) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        mx = mx << 1;
      end
    end
    for (int i = 0; i < 3; i++) v[i] = neg[i] ? -$signed(m[i]) : $signed(m[i]);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] saturate(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Offset of the point along the normalized rejection of the axis from the direction.
  function automatic pra_pkg::pra_out_t project_point(input pra_pkg::pra_in_t t);
    pra_pkg::pra_out_t r;
    logic signed [63:0] a[3], d[3], c[3], p[3], pos[3];
    logic signed [63:0] delta, off;
    logic [63:0] len2, len, dm, q, m;
    bit neg;
    a = '{64'(t.axis_x), 64'(t.axis_y), 64'(t.axis_z)};
    d = '{64'(t.dir_x), 64'(t.dir_y), 64'(t.dir_z)};
    pos = '{64'(t.pos_x), 64'(t.pos_y), 64'(t.pos_z)};
    r.out_x = t.pos_x;
    r.out_y = t.pos_y;
    r.out_z = t.pos_z;
    if (threshold <= t.dir_y || t.force_project) begin
      c[0] = a[2] * d[1] - a[1] * d[2];
      c[1] = a[0] * d[2] - a[2] * d[0];
      c[2] = a[1] * d[0] - a[0] * d[1];
      scale_vector(c, 31, 0, 1'b0);
      p[0] = c[1] * d[2] - c[2] * d[1];
      p[1] = c[2] * d[0] - c[0] * d[2];
      p[2] = c[0] * d[1] - c[1] * d[0];
      if (p[0] == 0 && p[1] == 0 && p[2] == 0) begin
        r.status = pra_pkg::ST_ZERO_LEN;
      end else begin
        delta = 64'(t.target_height) - 64'(t.ref_height);
        dm = magnitude(delta);
        scale_vector(p, 30, 29, 1'b1);
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
          m = magnitude(p[i]);
          len2 = len2 + m * m;
        end
        len = floor_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
          q = (dm * magnitude(p[i]) + len / 2) / len;
          neg = (delta < 0) != (p[i] < 0);
          off = neg ? -$signed(q) : $signed(q);
          pos[i] = 64'(saturate(pos[i] + off));
        end
        r.out_x = pos[0][31:0];
        r.out_y = pos[1][31:0];
        r.out_z = pos[2][31:0];
        r.status = pra_pkg::ST_PROJECTED;
      end
    end else begin
      r.status = pra_pkg::ST_BELOW;
    end
    return r;
  endfunction

  // Driver: offers queued items with random idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_points.push_back(project_point(in_ch.data));
        sent_count <= sent_count + 1;
      end
      if (pending_points.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_points.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and applies receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    pra_pkg::pra_out_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        if (expected_points.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) $display("ERROR: result with nothing expected: %p",
                                             out_ch.data);
        end else begin
          want = expected_points.pop_front();
          if (want.status <= pra_pkg::ST_BELOW) status_seen[want.status]++;
          if (out_ch.data.out_x !== want.out_x || out_ch.data.out_y !== want.out_y ||
              out_ch.data.out_z !== want.out_z || out_ch.data.status !== want.status) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("ERROR: point mismatch: expected %h %h %h st %0d, got %h %h %h st %0d",
                       want.out_x, want.out_y, want.out_z, want.status, out_ch.data.out_x,
                       out_ch.data.out_y, out_ch.data.out_z, out_ch.data.status);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        stimulus_done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_threshold(input logic signed [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pra_pkg::CFG_ADDR_W'(ADDR_MIN_DIR_Y);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    threshold = value;
  endtask

  // Waits until every queued item was sent and every result arrived.
  task automatic drain();
    while (pending_points.size() != 0 || in_ch.valid || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5, 0))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(262144, 0)) - 131072);
      3: return 32'(int'($urandom_range(1 << 24, 0)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  function automatic pra_pkg::pra_in_t random_point();
    pra_pkg::pra_in_t t;
    t.axis_x = rand_word();
    t.axis_y = rand_word();
    t.axis_z = rand_word();
    t.dir_x = rand_word();
    t.dir_y = rand_word();
    t.dir_z = rand_word();
    t.pos_x = rand_word();
    t.pos_y = rand_word();
    t.pos_z = rand_word();
    t.target_height = rand_word();
    t.ref_height = rand_word();
    t.force_project = $urandom_range(1, 0);
    // Axis parallel to the direction gives the zero-length fallback.
    if ($urandom_range(19, 0) == 0) begin
      t.axis_x = t.dir_x;
      t.axis_y = t.dir_y;
      t.axis_z = t.dir_z;
    end
    return t;
  endfunction

  function automatic pra_pkg::pra_in_t make_point(input logic [31:0] ax, ay, az, dx, dy, dz,
                                                  px, py, pz, th, rh, input logic fp);
    pra_pkg::pra_in_t t;
    t = '{ax, ay, az, dx, dy, dz, px, py, pz, th, rh, fp};
    return t;
  endfunction

  localparam logic [31:0] ONE = 32'h00010000;
  localparam logic [31:0] MAXV = 32'h7fffffff;
  localparam logic [31:0] MINV = 32'h80000000;

  // Stimulus sequence through the idling phases and threshold settings.
  initial begin
    int unsigned phase_items;
    logic signed [31:0] thresholds[4];
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    threshold = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    result_count = 0;
    sent_count = 0;
    quiet_cycles = 0;
    stimulus_done = 0;
    rst_ni = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    // Directed points at reset threshold: plain projection, parallel axis,
    // below threshold, forced, saturation and extreme fields.
    pending_points.push_back(make_point(ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 5 * ONE, ONE, 0));
    pending_points.push_back(make_point(0, ONE, 0, 0, ONE, 0, 7, 8, 9, ONE, 0, 0));
    pending_points.push_back(make_point(0, 0, 0, ONE, ONE, ONE, 1, 2, 3, ONE, 0, 0));
    pending_points.push_back(make_point(ONE, ONE, 0, 0, MINV, 0, 4, 5, 6, ONE, 0, 0));
    pending_points.push_back(make_point(ONE, ONE, 0, 0, MINV, 0, 4, 5, 6, ONE, 0, 1));
    pending_points.push_back(make_point(MAXV, MINV, MAXV, MINV, MAXV, MINV,
                                        MAXV, MINV, MAXV, MAXV, MINV, 0));
    pending_points.push_back(make_point(MINV, MINV, MINV, MAXV, MAXV, 1,
                                        MINV, MAXV, MINV, MINV, MAXV, 1));
    pending_points.push_back(make_point(ONE, 0, ONE, 1, MAXV, 0, MAXV, MAXV, MINV,
                                        MAXV, MINV, 0));
    pending_points.push_back(make_point(1, 2, 3, 3, 2, 1, MINV, MINV, MAXV, MINV, MAXV, 0));
    pending_points.push_back(make_point(ONE, 0, 0, 0, 0, 0, 1, 1, 1, ONE, 0, 1));
    pending_points.push_back(make_point(MAXV, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_points.push_back(make_point(ONE, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE, 0));
    drain();

    thresholds = '{32'sh7fffffff, 32'sh80000000, 32'sh00008000, -32'sh00010000};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) write_threshold(thresholds[(ph / 2) % 4]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      phase_items = NUM_RANDOM / 8;
      for (int k = 0; k < phase_items; k++) begin
        pending_points.push_back(random_point());
        // Once, in phase 3, let the block run dry before sending more.
        if (k == phase_items / 2 && ph == 3) begin
          drain();
        end
      end
      drain();
    end
    write_threshold(32'sh0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < 10; k++) pending_points.push_back(random_point());
    drain();
    stimulus_done = 1;

    $display("Covered %0d points: %0d projected, %0d zero-length, %0d below threshold.",
             sent_count, status_seen[0], status_seen[1], status_seen[2]);
    $display("Thresholds at both extremes, idle and stall mixes on both channels.");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/pra_pkg.sv
design/pra_chan_if.sv
design/pra_front.sv
design/pra_fifo.sv
design/pra_isqrt.sv
design/pra_div.sv
design/pra_back.sv
design/project_point_along_rejected_axis_unit.sv
tb/project_point_along_rejected_axis_unit_tb.sv
